### rtl/core/bsm_pkg.sv
package bsm_pkg;

  // Request command codes
  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_RESYNC = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_PRG    = 2'd1;
  localparam logic [1:0] KIND_CHR    = 2'd2;

  // Register decode: {address[15:13], address[0]}
  localparam logic [3:0] REG_BANK_SEL  = 4'b100_0;
  localparam logic [3:0] REG_BANK_DATA = 4'b100_1;
  localparam logic [3:0] REG_MIRROR    = 4'b101_0;
  localparam logic [3:0] REG_IRQ_COUNT = 4'b110_0;
  localparam logic [3:0] REG_IRQ_LATCH = 4'b110_1;
  localparam logic [3:0] REG_IRQ_OFF   = 4'b111_0;
  localparam logic [3:0] REG_IRQ_ON    = 4'b111_1;

  localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;

  // Bank store: entries 0-3 program banks, 4-11 pattern banks
  localparam int unsigned BANK_ENTRIES = 12;
  localparam logic [3:0]  CHR_BASE     = 4'd4;

  typedef enum logic [2:0] {
    M_STATUS,
    M_SEL,
    M_PAIR,
    M_ONE,
    M_PRG,
    M_RESYNC
  } mode_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] slot;
    logic       rd_en;
    logic       wr_en;
    logic [3:0] idx;
    logic [7:0] imm;
    logic       last;
  } step_t;

  function automatic logic [7:0] bank_reset_val(input logic [3:0] idx);
    logic [7:0] v;
    v = 8'd0;
    case (idx)
      4'd0:    v = 8'h00;
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h3E;
      4'd3:    v = 8'h3F;
      default: v = {5'd0, 3'(idx - CHR_BASE)};
    endcase
    return v;
  endfunction

  // One result of a request: what it reads or writes and how it is labeled
  function automatic step_t step_info(input mode_t mode, input logic [3:0] cnt,
                                      input logic [7:0] bsel, input logic [7:0] dat,
                                      input logic chr_chg);
    step_t      s;
    logic [2:0] r;
    logic [2:0] hi;
    logic [2:0] e;
    logic [3:0] cm2;
    logic [3:0] cm4;
    logic [2:0] rm2;
    logic [2:0] pidx;
    s    = '0;
    r    = bsel[2:0];
    hi   = {bsel[7], 2'b00};
    e    = {1'b0, r[0], 1'b0};
    cm2  = cnt - 4'd2;
    cm4  = cnt - 4'd4;
    rm2  = r - 3'd2;
    pidx = cm2[2:0] ^ hi;
    s.kind = KIND_STATUS;
    unique case (mode)
      M_STATUS: begin
        s.last = 1'b1;
      end
      M_SEL: begin
        if (cnt < 4'd2) begin
          s.kind  = KIND_PRG;
          s.slot  = cnt[0] ? 3'd2 : 3'd0;
          s.rd_en = 1'b1;
          s.idx   = {2'b00, bsel[6] ^ cnt[0], 1'b0};
          s.last  = (cnt == 4'd1) && !chr_chg;
        end else begin
          s.kind  = KIND_CHR;
          s.slot  = cm2[2:0];
          s.rd_en = 1'b1;
          s.idx   = {1'b0, pidx} + CHR_BASE;
          s.last  = (cnt == 4'd9);
        end
      end
      M_PAIR: begin
        s.kind  = KIND_CHR;
        s.slot  = hi | (e | {2'b00, cnt[0]});
        s.wr_en = 1'b1;
        s.idx   = {1'b0, e | {2'b00, cnt[0]}} + CHR_BASE;
        s.imm   = cnt[0] ? (dat | 8'h01) : (dat & 8'hFE);
        s.last  = cnt[0];
      end
      M_ONE: begin
        s.kind  = KIND_CHR;
        s.slot  = (hi ^ 3'd4) | {1'b0, rm2[1:0]};
        s.wr_en = 1'b1;
        s.idx   = {1'b0, r} + 4'd6;
        s.imm   = dat;
        s.last  = 1'b1;
      end
      M_PRG: begin
        s.kind  = KIND_PRG;
        s.slot  = r[0] ? 3'd1 : (bsel[6] ? 3'd2 : 3'd0);
        s.wr_en = 1'b1;
        s.idx   = {3'b000, r[0]};
        s.imm   = dat & 8'h3F;
        s.last  = 1'b1;
      end
      M_RESYNC: begin
        s.kind  = (cnt < CHR_BASE) ? KIND_PRG : KIND_CHR;
        s.slot  = (cnt < CHR_BASE) ? cnt[2:0] : cm4[2:0];
        s.rd_en = 1'b1;
        s.idx   = cnt;
        s.last  = (cnt == 4'd11);
      end
      default: begin
        s.last = 1'b1;
      end
    endcase
    return s;
  endfunction

endpackage

### rtl/core/bank_switch_mapper_with_scanline_irq.sv
// Bank-switching cartridge mapper with a scanline interrupt counter. Each
// request is a CPU register write, a scanline tick or a resync; the block
// answers with one result per slot/bank mapping the request changes (a
// resync announces all four program and eight pattern slots), or with one
// status-only result when nothing is remapped. Every result carries the
// interrupt level and the mirroring bit as they stand after the request,
// and last marks the final result of a request. Bank numbers live in a
// 12-entry synchronous RAM (program slots at 0-3, pattern slots at 4-11)
// with a valid bit per entry, so reset and resync take effect at once and
// no clearing pass is needed. A request produces 1 to 12 results: the
// block accepts it, issues the first RAM access, then emits one result
// per cycle while the output is not stalled, as the single RAM port
// streams reads or writes. in_stall is high while a request is in
// flight. four_screen is written through the cfg channel, which is
// always ready; write it only while idle.
module bank_switch_mapper_with_scanline_irq (
  input  logic       clk,
  input  logic       rst,
  // config
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  logic [15:0] address,
  input  logic [7:0] data,
  input  logic [8:0] scanline,
  input  logic       rendering_on,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [2:0] slot,
  output logic [7:0] bank,
  output logic       irq_line,
  output logic       mirror_horizontal,
  output logic       last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_EMIT
  } state_t;

  state_t          state;
  bsm_pkg::mode_t  mode;
  logic [3:0]      cnt;
  logic            chr_chg;
  logic [7:0]      dreg;

  // scalar mapper state
  logic [7:0] bank_select;
  logic [7:0] irq_count;
  logic [7:0] irq_latch;
  logic       reload_pending;
  logic       irq_enabled;
  logic       irq_pending;
  logic       mirroring;
  logic       four_screen;

  // bank RAM
  logic [7:0] bank_mem [bsm_pkg::BANK_ENTRIES];
  logic [bsm_pkg::BANK_ENTRIES-1:0] vld;
  logic [7:0] rd_data;
  logic       rd_vld;
  logic [3:0] rd_idx;
  logic [7:0] rd_value;

  bsm_pkg::step_t s_cur;
  bsm_pkg::step_t s_nxt;
  bsm_pkg::step_t s_iss;
  logic [3:0]     cnt_inc;
  logic           in_accept;
  logic           out_free;
  logic           emit_load;
  logic           issue_go;

  // request decode
  logic [3:0]     reg_code;
  logic [7:0]     sel_diff;
  logic [7:0]     tick_cnt0;
  logic [7:0]     tick_cnt1;
  logic           tick_act;
  bsm_pkg::mode_t mode_next;
  logic [3:0]     cnt_start;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign cnt_inc = cnt + 4'd1;
  assign s_cur   = bsm_pkg::step_info(mode, cnt, bank_select, dreg, chr_chg);
  assign s_nxt   = bsm_pkg::step_info(mode, cnt_inc, bank_select, dreg, chr_chg);
  assign s_iss   = (state == ST_ISSUE) ? s_cur : s_nxt;

  assign emit_load = (state == ST_EMIT) && out_free;
  // next RAM access goes out as the current result is loaded
  assign issue_go  = (state == ST_ISSUE) || (emit_load && !s_cur.last);

  // invalid entries read as their reset value
  assign rd_value = rd_vld ? rd_data : bsm_pkg::bank_reset_val(rd_idx);

  assign reg_code = {address[15:13], address[0]};
  assign sel_diff = bank_select ^ data;

  // scanline counter: line 0 pre-decrement, reload on zero, then decrement
  assign tick_act  = (scanline <= bsm_pkg::LAST_VISIBLE_LINE) && rendering_on &&
                     irq_enabled && !reload_pending;
  assign tick_cnt0 = ((scanline == 9'd0) && (irq_count != 8'd0)) ?
                     irq_count - 8'd1 : irq_count;
  assign tick_cnt1 = ((tick_cnt0 == 8'd0) ? irq_latch : tick_cnt0) - 8'd1;

  always_comb begin
    mode_next = bsm_pkg::M_STATUS;
    cnt_start = 4'd0;
    unique case (cmd)
      bsm_pkg::CMD_WRITE: begin
        if (reg_code == bsm_pkg::REG_BANK_SEL) begin
          if (sel_diff[6] || sel_diff[7]) begin
            mode_next = bsm_pkg::M_SEL;
            cnt_start = sel_diff[6] ? 4'd0 : 4'd2;
          end
        end else if (reg_code == bsm_pkg::REG_BANK_DATA) begin
          if (bank_select[2:1] == 2'b00) begin
            mode_next = bsm_pkg::M_PAIR;
          end else if (bank_select[2:1] == 2'b11) begin
            mode_next = bsm_pkg::M_PRG;
          end else begin
            mode_next = bsm_pkg::M_ONE;
          end
        end
      end
      bsm_pkg::CMD_RESYNC: mode_next = bsm_pkg::M_RESYNC;
      default:             mode_next = bsm_pkg::M_STATUS;
    endcase
  end

  // RAM array, one port
  always_ff @(posedge clk) begin
    if (issue_go && s_iss.wr_en) begin
      bank_mem[s_iss.idx] <= s_iss.imm;
    end
    if (issue_go && s_iss.rd_en) begin
      rd_data <= bank_mem[s_iss.idx];
      rd_vld  <= vld[s_iss.idx];
      rd_idx  <= s_iss.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (in_accept && (cmd == bsm_pkg::CMD_RESYNC)) begin
      vld <= '0;
    end else if (issue_go && s_iss.wr_en) begin
      vld[s_iss.idx] <= 1'b1;
    end
  end

  // sequencer, mapper state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      mode           <= bsm_pkg::M_STATUS;
      cnt            <= 4'd0;
      chr_chg        <= 1'b0;
      bank_select    <= 8'd0;
      irq_count      <= 8'd0;
      irq_latch      <= 8'd0;
      reload_pending <= 1'b0;
      irq_enabled    <= 1'b0;
      irq_pending    <= 1'b0;
      mirroring      <= 1'b0;
      four_screen    <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        four_screen <= cfg_data;
      end
      // a result taken this cycle frees the register unless the next loads
      if (out_valid && !out_stall && !emit_load) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            state   <= ST_ISSUE;
            mode    <= mode_next;
            cnt     <= cnt_start;
            chr_chg <= sel_diff[7];
            dreg    <= data;
            if (cmd == bsm_pkg::CMD_WRITE) begin
              unique case (reg_code)
                bsm_pkg::REG_BANK_SEL: bank_select <= data;
                bsm_pkg::REG_MIRROR: begin
                  if (!four_screen) begin
                    mirroring <= data[0];
                  end
                end
                bsm_pkg::REG_IRQ_COUNT: begin
                  irq_count      <= data;
                  reload_pending <= 1'b0;
                end
                bsm_pkg::REG_IRQ_LATCH: begin
                  irq_latch      <= data;
                  reload_pending <= 1'b0;
                end
                bsm_pkg::REG_IRQ_OFF: begin
                  irq_enabled    <= 1'b0;
                  reload_pending <= 1'b0;
                  irq_pending    <= 1'b0;
                end
                bsm_pkg::REG_IRQ_ON: begin
                  irq_enabled    <= 1'b1;
                  reload_pending <= 1'b0;
                end
                default: ;
              endcase
            end else if (cmd == bsm_pkg::CMD_TICK) begin
              if (tick_act) begin
                irq_count <= tick_cnt1;
                if (tick_cnt0 == 8'd0) begin
                  reload_pending <= 1'b1;
                  irq_pending    <= 1'b1;
                end
              end
            end else if (cmd == bsm_pkg::CMD_RESYNC) begin
              bank_select    <= 8'd0;
              irq_count      <= 8'd0;
              irq_latch      <= 8'd0;
              reload_pending <= 1'b0;
              irq_enabled    <= 1'b0;
            end
          end
        end
        ST_ISSUE: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            kind              <= s_cur.kind;
            slot              <= s_cur.slot;
            bank              <= s_cur.rd_en ? rd_value : s_cur.imm;
            irq_line          <= irq_pending;
            mirror_horizontal <= mirroring;
            last              <= s_cur.last;
            if (s_cur.last) begin
              state <= ST_IDLE;
            end else begin
              cnt <= cnt_inc;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_issues: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_ISSUE))
    else $error("accepted request did not start a RAM access");

  a_resync_clears: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (cmd == bsm_pkg::CMD_RESYNC)) |=> (vld == '0))
    else $error("resync left bank entries valid");

  a_last_idles: assert property (@(posedge clk) disable iff (rst)
    (emit_load && s_cur.last) |=> (state == ST_IDLE))
    else $error("sequencer kept running after final result");

  a_status_stable: assert property (@(posedge clk) disable iff (rst)
    ((state != ST_IDLE) && $past(state != ST_IDLE)) |->
      ($stable(irq_pending) && $stable(mirroring)))
    else $error("irq or mirroring changed mid-request");
`endif

endmodule
